// ===== hw/rtl/sbmv_pkg.sv =====
// ----------------------------------------------------------------------------
// sbmv_pkg
// shared types and constants of the 6x6 block sparse matrix-vector unit
// ----------------------------------------------------------------------------
package sbmv_pkg;

    localparam int BLOCK   = 6;
    localparam int IN_W    = 32;
    localparam int ACC_W   = 64;
    localparam int NODE_W  = 12;
    localparam int SUB_W   = 3;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_MAT  = 1'b1;

    typedef struct packed {
        logic                   mode;
        logic [NODE_W-1:0]      node;
        logic [SUB_W-1:0]       sub_row;
        logic signed [IN_W-1:0] v0;
        logic signed [IN_W-1:0] v1;
        logic signed [IN_W-1:0] v2;
        logic signed [IN_W-1:0] v3;
        logic signed [IN_W-1:0] v4;
        logic signed [IN_W-1:0] v5;
        logic                   end_of_row;
    } t_in_item;

    typedef struct packed {
        logic [NODE_W-1:0]       row_index;
        logic signed [ACC_W-1:0] y0;
        logic signed [ACC_W-1:0] y1;
        logic signed [ACC_W-1:0] y2;
        logic signed [ACC_W-1:0] y3;
        logic signed [ACC_W-1:0] y4;
        logic signed [ACC_W-1:0] y5;
    } t_out_item;

    typedef struct packed {
        logic mul_en;
        logic add1_en;
        logic add2_en;
    } t_stage_ctl;

endpackage

// ===== hw/rtl/sbmv_if.sv =====
// ----------------------------------------------------------------------------
// sbmv_in_if / sbmv_out_if
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
interface sbmv_in_if;
    logic               valid;
    logic               ready;
    sbmv_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sbmv_out_if;
    logic                valid;
    logic                ready;
    sbmv_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/sbmv_lane.sv =====
// ----------------------------------------------------------------------------
// sbmv_lane
// one vector store column with its registered read and coefficient multiplier
// ----------------------------------------------------------------------------
module sbmv_lane #(
    parameter int NODES      = 4096,
    parameter int VALUE_BITS = 32,
    parameter int AW         = 12
) (
    input  logic                           i_clk,
    input  logic                           i_wr,
    input  logic                           i_rd,
    input  logic [AW-1:0]                  i_addr,
    input  logic signed [VALUE_BITS-1:0]   i_val,
    input  logic                           i_in_range,
    input  sbmv_pkg::t_stage_ctl           i_ctl,
    output logic signed [2*VALUE_BITS-1:0] o_prod
);

    logic [VALUE_BITS-1:0]           mem [NODES];
    logic signed [VALUE_BITS-1:0]    r_rd_data;
    logic signed [VALUE_BITS-1:0]    r_coef;
    logic                            r_in_range;
    logic signed [VALUE_BITS-1:0]    w_operand;
    logic signed [2*VALUE_BITS-1:0]  r_prod;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            mem[i_addr] <= i_val;
        end
        if (i_rd) begin
            r_rd_data  <= mem[i_addr];
            r_coef     <= i_val;
            r_in_range <= i_in_range;
        end
    end

    // out-of-range node reads as zero
    assign w_operand = r_in_range ? r_rd_data : '0;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= r_coef * w_operand;
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== hw/rtl/sbmv_merge.sv =====
// ----------------------------------------------------------------------------
// sbmv_merge
// adds the six lane products to the old row sum and saturates to 64 bits
// ----------------------------------------------------------------------------
module sbmv_merge #(
    parameter int VALUE_BITS = 32
) (
    input  logic                                  i_clk,
    input  sbmv_pkg::t_stage_ctl                  i_ctl,
    input  logic signed [2*VALUE_BITS-1:0]        i_prod [sbmv_pkg::BLOCK],
    input  logic signed [sbmv_pkg::ACC_W-1:0]     i_acc_old,
    output logic signed [sbmv_pkg::ACC_W-1:0]     o_sum
);

    localparam int W1 = sbmv_pkg::ACC_W + 1;
    localparam int W2 = sbmv_pkg::ACC_W + 2;
    localparam int W3 = sbmv_pkg::ACC_W + 3;

    logic signed [W1-1:0] r_s01, r_s23, r_s45;
    logic signed [W2-1:0] r_t, r_u;
    logic signed [W3-1:0] w_total;
    logic                 w_fits;

    always_ff @(posedge i_clk) begin
        if (i_ctl.add1_en) begin
            r_s01 <= W1'(i_prod[0]) + W1'(i_prod[1]);
            r_s23 <= W1'(i_prod[2]) + W1'(i_prod[3]);
            r_s45 <= W1'(i_prod[4]) + W1'(i_prod[5]);
        end
        if (i_ctl.add2_en) begin
            r_t <= W2'(r_s01) + W2'(r_s23);
            r_u <= W2'(r_s45) + W2'(i_acc_old);
        end
    end

    assign w_total = W3'(r_t) + W3'(r_u);
    assign w_fits  = (w_total[W3-1:sbmv_pkg::ACC_W-1] == '0) ||
                     (w_total[W3-1:sbmv_pkg::ACC_W-1] == '1);

    always_comb begin
        if (w_fits) begin
            o_sum = w_total[sbmv_pkg::ACC_W-1:0];
        end else if (w_total[W3-1]) begin
            o_sum = {1'b1, {(sbmv_pkg::ACC_W-1){1'b0}}};
        end else begin
            o_sum = {1'b0, {(sbmv_pkg::ACC_W-1){1'b1}}};
        end
    end

endmodule

// ===== hw/rtl/block6x6_sparse_matvec.sv =====
// ----------------------------------------------------------------------------
// block6x6_sparse_matvec
// 6x6 block compressed row sparse matrix-vector product, Q16.16 in, Q32.32 out
// ----------------------------------------------------------------------------
// i_item carries one item per transfer. mode 0 writes six vector entries of
// a node into the vector store, so loads stream at one per cycle while no
// block row item is in flight. mode 1 carries one row of a 6x6 block: six
// lanes read the node's entries and multiply in parallel, a merge stage adds
// the products to the sub-row sum over three adder stages, so a block row
// item occupies the unit (read, multiply, two add stages, final add and
// saturate) and no new item is taken until it is through. With end_of_row
// set, the row index and six sums are loaded into the output register at the
// end of the final stage and shown on o_result; the sums clear and the row
// counter advances. The output register lets the next item enter while a
// result waits; a second result stalls in the final stage until o_result
// transfers.
// Reset clears the sums, the row counter and the output valid; the vector
// store is undefined until written.
// ----------------------------------------------------------------------------
module block6x6_sparse_matvec #(
    parameter int NODES      = 4096,
    parameter int VALUE_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sbmv_in_if.sink    i_item,
    sbmv_out_if.source o_result
);

    localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int PW = 2 * VALUE_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ADD1 = 3'd2;
    localparam logic [2:0] S_ADD2 = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]                                r_state, n_state;
    logic [sbmv_pkg::SUB_W-1:0]                r_sub;
    logic                                      r_eor;
    logic [sbmv_pkg::NODE_W-1:0]               r_row_cnt;
    logic signed [sbmv_pkg::ACC_W-1:0]         r_acc [sbmv_pkg::BLOCK];
    logic                                      r_out_valid;
    sbmv_pkg::t_out_item                       r_res;

    logic                                      w_in_xfer;
    logic                                      w_in_range;
    logic [16:0]                               w_node_ext;
    logic [AW-1:0]                             w_addr;
    logic signed [VALUE_BITS-1:0]              w_vals [sbmv_pkg::BLOCK];
    logic signed [PW-1:0]                      w_prod [sbmv_pkg::BLOCK];
    logic                                      w_sub_ok;
    logic signed [sbmv_pkg::ACC_W-1:0]         w_acc_old;
    logic signed [sbmv_pkg::ACC_W-1:0]         w_sum;
    logic signed [sbmv_pkg::ACC_W-1:0]         w_y [sbmv_pkg::BLOCK];
    logic                                      w_stall;
    logic                                      w_commit;
    sbmv_pkg::t_stage_ctl                      w_ctl;

    assign i_item.ready = (r_state == S_IDLE);
    assign w_in_xfer    = i_item.valid && i_item.ready;

    assign w_node_ext = 17'(i_item.data.node);
    assign w_addr     = w_node_ext[AW-1:0];
    assign w_in_range = (w_node_ext < 17'(NODES));

    always_comb begin
        w_vals[0] = i_item.data.v0[VALUE_BITS-1:0];
        w_vals[1] = i_item.data.v1[VALUE_BITS-1:0];
        w_vals[2] = i_item.data.v2[VALUE_BITS-1:0];
        w_vals[3] = i_item.data.v3[VALUE_BITS-1:0];
        w_vals[4] = i_item.data.v4[VALUE_BITS-1:0];
        w_vals[5] = i_item.data.v5[VALUE_BITS-1:0];
    end

    assign w_ctl.mul_en  = (r_state == S_MUL);
    assign w_ctl.add1_en = (r_state == S_ADD1);
    assign w_ctl.add2_en = (r_state == S_ADD2);

    for (genvar k = 0; k < sbmv_pkg::BLOCK; k++) begin : g_lane
        sbmv_lane #(
            .NODES      (NODES),
            .VALUE_BITS (VALUE_BITS),
            .AW         (AW)
        ) u_lane (
            .i_clk      (i_clk),
            .i_wr       (w_in_xfer && (i_item.data.mode == sbmv_pkg::MODE_LOAD)
                         && w_in_range),
            .i_rd       (w_in_xfer && (i_item.data.mode == sbmv_pkg::MODE_MAT)),
            .i_addr     (w_addr),
            .i_val      (w_vals[k]),
            .i_in_range (w_in_range),
            .i_ctl      (w_ctl),
            .o_prod     (w_prod[k])
        );
    end

    // sub-row 6 or 7 adds nothing
    assign w_sub_ok  = (r_sub < sbmv_pkg::SUB_W'(sbmv_pkg::BLOCK));
    assign w_acc_old = w_sub_ok ? r_acc[r_sub] : '0;

    sbmv_merge #(
        .VALUE_BITS (VALUE_BITS)
    ) u_merge (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_prod    (w_prod),
        .i_acc_old (w_acc_old),
        .o_sum     (w_sum)
    );

    assign w_stall  = r_eor && r_out_valid && !o_result.ready;
    assign w_commit = (r_state == S_DONE) && !w_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer && (i_item.data.mode == sbmv_pkg::MODE_MAT)) begin
                    n_state = S_MUL;
                end
            end
            S_MUL:  n_state = S_ADD1;
            S_ADD1: n_state = S_ADD2;
            S_ADD2: n_state = S_DONE;
            S_DONE: begin
                if (!w_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        for (int k = 0; k < sbmv_pkg::BLOCK; k++) begin
            w_y[k] = (w_sub_ok && (r_sub == sbmv_pkg::SUB_W'(k))) ? w_sum : r_acc[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row_cnt   <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < sbmv_pkg::BLOCK; k++) begin
                r_acc[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                for (int k = 0; k < sbmv_pkg::BLOCK; k++) begin
                    r_acc[k] <= r_eor ? '0 : w_y[k];
                end
                if (r_eor) begin
                    r_row_cnt <= r_row_cnt + 1'b1;
                end
            end
            if (w_commit && r_eor) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_sub <= i_item.data.sub_row;
            r_eor <= i_item.data.end_of_row;
        end
        if (w_commit && r_eor) begin
            r_res.row_index <= r_row_cnt;
            r_res.y0        <= w_y[0];
            r_res.y1        <= w_y[1];
            r_res.y2        <= w_y[2];
            r_res.y3        <= w_y[3];
            r_res.y4        <= w_y[4];
            r_res.y5        <= w_y[5];
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_res;

`ifndef ASSERT_OFF
    a_mat_item_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && (i_item.data.mode == sbmv_pkg::MODE_MAT)) |=> (r_state == S_MUL))
        else $error("block row transfer did not start the multiply stage");

    a_row_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && r_eor) |=> (r_row_cnt == $past(r_row_cnt) + 1'b1) && r_out_valid)
        else $error("row counter or result valid wrong after a finished row");

    a_sums_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && r_eor) |=> (r_acc[0] == '0) && (r_acc[1] == '0) && (r_acc[2] == '0)
            && (r_acc[3] == '0) && (r_acc[4] == '0) && (r_acc[5] == '0))
        else $error("row sums not cleared after a finished row");
`endif

endmodule

// ===== tb/sbmv_result_checker.sv =====
// ----------------------------------------------------------------------------
// sbmv_result_checker
// watches both channels of the block sparse matrix-vector unit, keeps its own
// vector store, sub-row sums and row counter, predicts each finished row and
// compares every result transfer field by field against the oldest prediction
// ----------------------------------------------------------------------------
module sbmv_result_checker #(
    parameter int NODES = 4096
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sbmv_in_if   i_item,
    sbmv_out_if  i_result,
    output int   o_fail_count,
    output int   o_pending
);

    typedef logic signed [sbmv_pkg::IN_W-1:0]  t_lane [sbmv_pkg::BLOCK];
    typedef logic signed [sbmv_pkg::ACC_W-1:0] t_sums [sbmv_pkg::BLOCK];

    logic signed [sbmv_pkg::IN_W-1:0]  vec_mem [NODES*sbmv_pkg::BLOCK];
    logic signed [sbmv_pkg::ACC_W-1:0] row_acc [sbmv_pkg::BLOCK];
    logic [sbmv_pkg::NODE_W-1:0]       row_num;
    sbmv_pkg::t_out_item               finished_rows [$];
    int                                fail_count = 0;

    sbmv_pkg::t_in_item  in_xfer;
    sbmv_pkg::t_out_item got, want, row_done;
    t_lane               coef;
    t_sums               got_y, want_y;

    task automatic report_fail(input string msg);
        $display("%0t: %s", $realtime, msg);
        fail_count++;
    endtask

    // exact sum of the old value and six products, saturated once to 64 bits
    function automatic logic signed [sbmv_pkg::ACC_W-1:0] add_row_dot(
        input logic signed [sbmv_pkg::ACC_W-1:0] acc_in,
        input t_lane                             lanes,
        input int                                node
    );
        logic signed [sbmv_pkg::ACC_W+3:0] total;
        logic signed [sbmv_pkg::ACC_W-1:0] prod;
        logic signed [sbmv_pkg::IN_W-1:0]  entry;
        total = acc_in;
        for (int k = 0; k < sbmv_pkg::BLOCK; k++) begin
            entry = (node < NODES) ? vec_mem[node*sbmv_pkg::BLOCK + k] : '0;
            prod  = lanes[k] * entry;
            total = total + prod;
        end
        if (total[sbmv_pkg::ACC_W+3:sbmv_pkg::ACC_W-1] == '0 ||
            total[sbmv_pkg::ACC_W+3:sbmv_pkg::ACC_W-1] == '1) begin
            return total[sbmv_pkg::ACC_W-1:0];
        end
        return total[sbmv_pkg::ACC_W+3] ? {1'b1, {(sbmv_pkg::ACC_W-1){1'b0}}}
                                         : {1'b0, {(sbmv_pkg::ACC_W-1){1'b1}}};
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (row_acc[k]) row_acc[k] = '0;
            row_num = '0;
            finished_rows.delete();
        end else begin
            if (i_result.valid && i_result.ready) begin
                got = i_result.data;
                if (finished_rows.size() == 0) begin
                    report_fail($sformatf("row %0d delivered with nothing outstanding",
                                          got.row_index));
                end else begin
                    want   = finished_rows.pop_front();
                    got_y  = '{got.y0, got.y1, got.y2, got.y3, got.y4, got.y5};
                    want_y = '{want.y0, want.y1, want.y2, want.y3, want.y4, want.y5};
                    if (got.row_index !== want.row_index) begin
                        report_fail($sformatf("row_index: got %0d expected %0d",
                                              got.row_index, want.row_index));
                    end
                    for (int k = 0; k < sbmv_pkg::BLOCK; k++) begin
                        if (got_y[k] !== want_y[k]) begin
                            report_fail($sformatf("row %0d y%0d: got %h expected %h",
                                                  want.row_index, k, got_y[k], want_y[k]));
                        end
                    end
                end
            end
            if (i_item.valid && i_item.ready) begin
                in_xfer = i_item.data;
                coef = '{in_xfer.v0, in_xfer.v1, in_xfer.v2,
                         in_xfer.v3, in_xfer.v4, in_xfer.v5};
                if (in_xfer.mode == sbmv_pkg::MODE_LOAD) begin
                    if (int'(in_xfer.node) < NODES) begin
                        for (int k = 0; k < sbmv_pkg::BLOCK; k++) begin
                            vec_mem[int'(in_xfer.node)*sbmv_pkg::BLOCK + k] = coef[k];
                        end
                    end
                end else begin
                    if (in_xfer.sub_row < sbmv_pkg::BLOCK) begin
                        row_acc[in_xfer.sub_row] = add_row_dot(row_acc[in_xfer.sub_row],
                                                               coef, int'(in_xfer.node));
                    end
                    if (in_xfer.end_of_row) begin
                        row_done.row_index = row_num;
                        row_done.y0 = row_acc[0];
                        row_done.y1 = row_acc[1];
                        row_done.y2 = row_acc[2];
                        row_done.y3 = row_acc[3];
                        row_done.y4 = row_acc[4];
                        row_done.y5 = row_acc[5];
                        finished_rows.push_back(row_done);
                        foreach (row_acc[k]) row_acc[k] = '0;
                        row_num = row_num + 1'b1;
                    end
                end
            end
        end
        o_pending <= finished_rows.size();
    end

    assign o_fail_count = fail_count;

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the 6x6 block sparse matrix-vector unit: a short
// directed run over value extremes, saturation and odd sub-rows, then random
// vector loads and block rows; both channels idle at random
// ----------------------------------------------------------------------------
module testbench;

    localparam int NODES        = 4096;
    localparam int RANDOM_ITEMS = 1150;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int SETTLE       = 20;

    localparam int SPREAD_FULL    = 0;
    localparam int SPREAD_SMALL   = 1;
    localparam int SPREAD_EXTREME = 2;

    typedef logic signed [sbmv_pkg::IN_W-1:0] t_value;
    typedef t_value t_value_set [sbmv_pkg::BLOCK];

    localparam t_value MAX_Q  = 32'sh7FFF_FFFF;
    localparam t_value MIN_Q  = 32'sh8000_0000;
    localparam t_value ONE_Q  = 32'sh0001_0000;
    localparam t_value ZERO_Q = 32'sh0000_0000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    int   items_sent  = 0;
    bit   idle_on     = 1'b1;
    bit   node_loaded [NODES];
    logic [sbmv_pkg::NODE_W-1:0] loaded_nodes [$];

    sbmv_in_if  in_ch ();
    sbmv_out_if res_ch ();

    block6x6_sparse_matvec #(
        .NODES      (NODES),
        .VALUE_BITS (sbmv_pkg::IN_W)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (in_ch),
        .o_result (res_ch)
    );

    sbmv_result_checker #(
        .NODES (NODES)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (in_ch),
        .i_result     (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int pick_spread();
        int r;
        r = $urandom_range(0, 4);
        return (r < 2) ? SPREAD_FULL : (r < 4) ? SPREAD_SMALL : SPREAD_EXTREME;
    endfunction

    function automatic t_value_set draw_set(input int spread);
        t_value_set vals;
        for (int k = 0; k < sbmv_pkg::BLOCK; k++) begin
            case (spread)
                SPREAD_FULL:  vals[k] = t_value'($urandom);
                SPREAD_SMALL: vals[k] = t_value'($urandom_range(0, 'h7FFFF) - 'h40000);
                default: begin
                    case ($urandom_range(0, 4))
                        0:       vals[k] = MAX_Q;
                        1:       vals[k] = MIN_Q;
                        2:       vals[k] = ZERO_Q;
                        3:       vals[k] = ONE_Q;
                        default: vals[k] = -ONE_Q;
                    endcase
                end
            endcase
        end
        return vals;
    endfunction

    // only nodes already written are ever read
    function automatic logic [sbmv_pkg::NODE_W-1:0] pick_node();
        return loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)];
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_item(
        input logic                        mode,
        input logic [sbmv_pkg::NODE_W-1:0] node,
        input logic [sbmv_pkg::SUB_W-1:0]  sub,
        input t_value_set                  vals,
        input logic                        eor
    );
        sbmv_pkg::t_in_item it;
        int                 gap;
        it.mode       = mode;
        it.node       = node;
        it.sub_row    = sub;
        it.v0         = vals[0];
        it.v1         = vals[1];
        it.v2         = vals[2];
        it.v3         = vals[3];
        it.v4         = vals[4];
        it.v5         = vals[5];
        it.end_of_row = eor;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        if (mode == sbmv_pkg::MODE_LOAD) begin
            if (!node_loaded[node]) begin
                node_loaded[node] = 1'b1;
                loaded_nodes.push_back(node);
            end
        end
        items_sent++;
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin : result_sink
        int stall;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            stall = idle_on ? $urandom_range(0, 5) : 0;
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
        end
    end

    initial begin : stimulus
        int                          stop_at;
        int                          next_drain;
        int                          kind;
        int                          spread;
        int                          n;
        logic [sbmv_pkg::NODE_W-1:0] col;

        i_rst_n     = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // vector loads at the ends of the node and value ranges
        send_item(sbmv_pkg::MODE_LOAD, 12'h000, 3'd0, '{6{MAX_Q}}, 1'b0);
        send_item(sbmv_pkg::MODE_LOAD, 12'hFFF, 3'd7, '{6{MIN_Q}}, 1'b0);
        send_item(sbmv_pkg::MODE_LOAD, 12'hAAA, 3'd5,
                  '{ONE_Q, -ONE_Q, ZERO_Q, MAX_Q, MIN_Q, 32'sh5555_5555}, 1'b0);
        // end flag on a load is ignored
        send_item(sbmv_pkg::MODE_LOAD, 12'h555, 3'd2,
                  '{ONE_Q, ONE_Q, ONE_Q, -ONE_Q, -ONE_Q, -ONE_Q}, 1'b1);
        // positive rail, then back off it
        send_item(sbmv_pkg::MODE_MAT, 12'hFFF, 3'd0, '{6{MIN_Q}}, 1'b0);
        send_item(sbmv_pkg::MODE_MAT, 12'h000, 3'd0,
                  '{MIN_Q, ZERO_Q, ZERO_Q, ZERO_Q, ZERO_Q, ZERO_Q}, 1'b0);
        send_item(sbmv_pkg::MODE_MAT, 12'h000, 3'd1, '{6{MAX_Q}}, 1'b0);
        // negative rail, pushed further
        send_item(sbmv_pkg::MODE_MAT, 12'hFFF, 3'd2, '{6{MAX_Q}}, 1'b0);
        send_item(sbmv_pkg::MODE_MAT, 12'hFFF, 3'd2, '{6{MAX_Q}}, 1'b0);
        send_item(sbmv_pkg::MODE_MAT, 12'hAAA, 3'd3,
                  '{MIN_Q, MAX_Q, ONE_Q, -ONE_Q, 32'shAAAA_AAAA, ZERO_Q}, 1'b0);
        send_item(sbmv_pkg::MODE_MAT, 12'h555, 3'd4, '{6{ONE_Q}}, 1'b0);
        send_item(sbmv_pkg::MODE_MAT, 12'h555, 3'd5, '{6{-ONE_Q}}, 1'b0);
        // sub-rows past the block add nothing but still close the row
        send_item(sbmv_pkg::MODE_MAT, 12'h555, 3'd6, '{6{MAX_Q}}, 1'b0);
        send_item(sbmv_pkg::MODE_MAT, 12'hAAA, 3'd7, '{6{MIN_Q}}, 1'b1);
        // single-item rows
        send_item(sbmv_pkg::MODE_MAT, 12'hAAA, 3'd5, '{6{MAX_Q}}, 1'b1);
        send_item(sbmv_pkg::MODE_MAT, 12'h000, 3'd4, '{6{ZERO_Q}}, 1'b1);
        // overwrite a node and read it back
        send_item(sbmv_pkg::MODE_LOAD, 12'h000, 3'd3,
                  '{-ONE_Q, ONE_Q, MIN_Q, MAX_Q, ZERO_Q, 32'sh0000_0001}, 1'b0);
        send_item(sbmv_pkg::MODE_MAT, 12'h000, 3'd1, '{6{-ONE_Q}}, 1'b1);
        drain_results();

        stop_at    = items_sent + RANDOM_ITEMS;
        next_drain = items_sent + 300;
        while (items_sent < stop_at) begin
            kind   = $urandom_range(0, 9);
            spread = pick_spread();
            if ($urandom_range(0, 15) == 0) idle_on = !idle_on;
            if (kind < 3) begin
                n = $urandom_range(1, 4);
                repeat (n) begin
                    send_item(sbmv_pkg::MODE_LOAD,
                              sbmv_pkg::NODE_W'($urandom_range(0, NODES - 1)),
                              sbmv_pkg::SUB_W'($urandom), draw_set(spread), 1'b0);
                end
            end else if (kind < 7) begin
                // whole 6x6 blocks, sub-rows in order
                n = $urandom_range(1, 3);
                for (int b = 0; b < n; b++) begin
                    col = pick_node();
                    for (int s = 0; s < sbmv_pkg::BLOCK; s++) begin
                        send_item(sbmv_pkg::MODE_MAT, col, sbmv_pkg::SUB_W'(s),
                                  draw_set(spread),
                                  (b == n - 1) && (s == sbmv_pkg::BLOCK - 1));
                    end
                end
            end else if (kind < 9) begin
                // ragged row, any sub-row
                n = $urandom_range(1, 5);
                for (int s = 0; s < n; s++) begin
                    send_item(sbmv_pkg::MODE_MAT, pick_node(),
                              sbmv_pkg::SUB_W'($urandom_range(0, 7)),
                              draw_set(spread), s == n - 1);
                end
            end else begin
                send_item(sbmv_pkg::MODE_LOAD,
                          sbmv_pkg::NODE_W'($urandom_range(0, NODES - 1)),
                          sbmv_pkg::SUB_W'($urandom), draw_set(spread), 1'b1);
                send_item(sbmv_pkg::MODE_MAT, pick_node(),
                          sbmv_pkg::SUB_W'($urandom_range(sbmv_pkg::BLOCK, 7)),
                          draw_set(spread), 1'b0);
            end
            if (items_sent >= next_drain) begin
                drain_results();
                next_drain = items_sent + 300;
            end
        end

        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
